>>> sv/fmpd_pkg.sv
// Package for the fast doubling Fibonacci mod 1000000007 block.
// Holds the modulus, Barrett constant, field widths and the final fold helper.
// No dependencies.
`default_nettype none

package fmpd_pkg;

  localparam int IDX_W = 64;  // index field width
  localparam int FIB_W = 30;  // residue width

  localparam logic [FIB_W-1:0] FIB_MOD = 30'd1000000007;
  // floor(2^60 / FIB_MOD), 31 bits
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  // Fold a value below 3*FIB_MOD into 0..FIB_MOD-1.
  function automatic logic [FIB_W-1:0] mod_fold(input logic [31:0] x);
    logic [32:0] d1;
    logic [32:0] d2;
    d1 = {1'b0, x} - {3'b000, FIB_MOD};
    d2 = {1'b0, x} - {2'b00, FIB_MOD, 1'b0};
    if (!d2[32]) begin
      return d2[FIB_W-1:0];
    end else if (!d1[32]) begin
      return d1[FIB_W-1:0];
    end else begin
      return x[FIB_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> sv/fibonacci_mod_prime_doubling_top.sv
// Fast doubling Fibonacci modulo 1000000007, iterative over the index bits.
// Depends on fmpd_pkg (modulus, Barrett constant, fold helper).
//
//   channel | ports                          | direction | width
//   --------+--------------------------------+-----------+------
//   input   | in_valid, in_ready, in_index   | in        | 64
//   result  | out_valid, out_ready,          | out       | 30
//           | out_fib_value                  |           |
//
// Multiplier: one shared 32x32 multiplier serves every walked index bit; each
//   modular product takes three passes (product, Barrett quotient, quotient
//   times modulus) plus a fold.
// Reset: rst_n synchronous, active low; clears the sequencer and the result valid.
// Stalls: in_ready is high only while idle. A finished result waits in the output
//   register; a new index is taken meanwhile, and its result holds in the done
//   state until the register frees up.
`default_nettype none

module fibonacci_mod_prime_doubling_top #(
  parameter int INDEX_BITS = fmpd_pkg::IDX_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [fmpd_pkg::IDX_W-1:0] in_index,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [fmpd_pkg::FIB_W-1:0]      out_fib_value
);

  import fmpd_pkg::*;

  // walked index width, held to 1..IDX_W
  localparam int WALK_BITS = (INDEX_BITS > IDX_W) ? IDX_W :
                             ((INDEX_BITS < 1) ? 1 : INDEX_BITS);
  localparam int CNT_W = (WALK_BITS > 1) ? $clog2(WALK_BITS) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TW   = 4'd1;  // twice = 2F(k+1) - F(k)
  localparam logic [3:0] S_MUL0 = 4'd2;  // P = a*b
  localparam logic [3:0] S_MUL1 = 4'd3;  // (P >> 29) * mu
  localparam logic [3:0] S_MUL2 = 4'd4;  // q * modulus
  localparam logic [3:0] S_MUL3 = 4'd5;  // fold P - q*modulus
  localparam logic [3:0] S_ODD  = 4'd6;  // F(k)^2 + F(k+1)^2
  localparam logic [3:0] S_UPD  = 4'd7;  // pick new pair, next bit
  localparam logic [3:0] S_DONE = 4'd8;

  // which modular product is in flight
  localparam logic [1:0] OP_EVEN = 2'd0;  // F(k) * twice
  localparam logic [1:0] OP_SQK  = 2'd1;  // F(k)^2
  localparam logic [1:0] OP_SQK1 = 2'd2;  // F(k+1)^2

  logic [3:0]            state_r, state_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [WALK_BITS-1:0]  idx_r, idx_nxt;
  logic [FIB_W-1:0]      fk_r, fk_nxt;
  logic [FIB_W-1:0]      fk1_r, fk1_nxt;
  logic [FIB_W-1:0]      tw_r, tw_nxt;
  logic [FIB_W-1:0]      ev_r, ev_nxt;
  logic [FIB_W-1:0]      sq1_r, sq1_nxt;
  logic [FIB_W-1:0]      sq2_r, sq2_nxt;
  logic [63:0]           prod_r, prod_nxt;
  logic [31:0]           plo_r, plo_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FIB_W-1:0]      out_val_r, out_val_nxt;

  // shared multiplier and fold unit
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic [31:0]      fold_in;
  logic [FIB_W-1:0] fold_out;

  assign mul_p    = mul_a * mul_b;
  assign fold_out = mod_fold(fold_in);

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_fib_value = out_val_r;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL0: begin
        case (op_r)
          OP_EVEN: begin
            mul_a = {2'b00, fk_r};
            mul_b = {2'b00, tw_r};
          end
          OP_SQK: begin
            mul_a = {2'b00, fk_r};
            mul_b = {2'b00, fk_r};
          end
          default: begin
            mul_a = {2'b00, fk1_r};
            mul_b = {2'b00, fk1_r};
          end
        endcase
      end
      S_MUL1: begin
        mul_a = {1'b0, prod_r[59:29]};
        mul_b = {1'b0, BARRETT_MU};
      end
      S_MUL2: begin
        mul_a = {1'b0, prod_r[61:31]};
        mul_b = {2'b00, FIB_MOD};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // fold input select; every source stays below 3*modulus
  always_comb begin
    case (state_r)
      S_TW:    fold_in = {1'b0, fk1_r, 1'b0} + {2'b00, FIB_MOD} - {2'b00, fk_r};
      S_MUL3:  fold_in = plo_r - prod_r[31:0];
      S_ODD:   fold_in = {2'b00, sq1_r} + {2'b00, sq2_r};
      S_UPD:   fold_in = {2'b00, ev_r} + {2'b00, sq1_r};
      default: fold_in = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    fk_nxt        = fk_r;
    fk1_nxt       = fk1_r;
    tw_nxt        = tw_r;
    ev_nxt        = ev_r;
    sq1_nxt       = sq1_r;
    sq2_nxt       = sq2_r;
    prod_nxt      = prod_r;
    plo_nxt       = plo_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt   = in_index[WALK_BITS-1:0];
          cnt_nxt   = CNT_W'(WALK_BITS - 1);
          fk_nxt    = '0;
          fk1_nxt   = FIB_W'(1);
          state_nxt = S_TW;
        end
      end
      S_TW: begin
        tw_nxt    = fold_out;
        op_nxt    = OP_EVEN;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        prod_nxt  = mul_p;
        plo_nxt   = mul_p[31:0];
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        prod_nxt  = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        prod_nxt  = mul_p;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        case (op_r)
          OP_EVEN: begin
            ev_nxt    = fold_out;
            op_nxt    = OP_SQK;
            state_nxt = S_MUL0;
          end
          OP_SQK: begin
            sq1_nxt   = fold_out;
            op_nxt    = OP_SQK1;
            state_nxt = S_MUL0;
          end
          default: begin
            sq2_nxt   = fold_out;
            state_nxt = S_ODD;
          end
        endcase
      end
      S_ODD: begin
        sq1_nxt   = fold_out;  // sq1 now holds F(2k+1)
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (idx_r[WALK_BITS-1]) begin
          fk_nxt  = sq1_r;
          fk1_nxt = fold_out;
        end else begin
          fk_nxt  = ev_r;
          fk1_nxt = sq1_r;
        end
        idx_nxt = idx_r << 1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_TW;
        end
      end
      S_DONE: begin
        // output register free, or freed by this transfer
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = fk_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    cnt_r     <= cnt_nxt;
    idx_r     <= idx_nxt;
    fk_r      <= fk_nxt;
    fk1_r     <= fk1_nxt;
    tw_r      <= tw_nxt;
    ev_r      <= ev_nxt;
    sq1_r     <= sq1_nxt;
    sq2_r     <= sq2_nxt;
    prod_r    <= prod_nxt;
    plo_r     <= plo_nxt;
    out_val_r <= out_val_nxt;
  end

endmodule

`default_nettype wire
